[hw/rtl/rphls_pkg.sv]
// shared types and constants of the programmer host link sequencer
`timescale 1ns / 1ps
package rphls_pkg;

  localparam int unsigned CHUNK_BYTES_DEF = 1024;
  localparam int unsigned ID_BYTES_DEF    = 8;
  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned MAX_RES         = 5;
  localparam logic [7:0]  PAD_BYTE        = 8'hFF;

  // input commands
  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_TEST   = 3'd2,
    CMD_IDENT  = 3'd3,
    CMD_FLASH  = 3'd4,
    CMD_BYTE   = 3'd5,
    CMD_PLUG   = 3'd6,
    CMD_REMOVE = 3'd7
  } cmd_e;

  // result kinds
  localparam logic [2:0] K_SEND  = 3'd0;
  localparam logic [2:0] K_STAT  = 3'd1;
  localparam logic [2:0] K_RDATA = 3'd2;
  localparam logic [2:0] K_ID    = 3'd3;
  localparam logic [2:0] K_CHUNK = 3'd4;
  localparam logic [2:0] K_FAIL  = 3'd5;
  localparam logic [2:0] K_PORT  = 3'd6;

  // board command bytes
  localparam logic [7:0] B_TEST    = 8'd1;
  localparam logic [7:0] B_IDENT   = 8'd2;
  localparam logic [7:0] B_READ    = 8'd4;
  localparam logic [7:0] B_ERASE   = 8'd5;
  localparam logic [7:0] B_WRITE   = 8'd6;
  localparam logic [7:0] B_GETMODE = 8'd7;
  localparam logic [7:0] B_TOBOOT  = 8'd8;
  localparam logic [7:0] B_TOPROG  = 8'd9;
  localparam logic [7:0] B_FLASH   = 8'd10;

  // status events
  localparam logic [4:0] S_WR_ERR     = 5'd0;
  localparam logic [4:0] S_ER_DONE    = 5'd1;
  localparam logic [4:0] S_ER_FAIL    = 5'd2;
  localparam logic [4:0] S_WR_DONE    = 5'd3;
  localparam logic [4:0] S_ERASING    = 5'd4;
  localparam logic [4:0] S_WR_TOT     = 5'd5;
  localparam logic [4:0] S_WR_CMP     = 5'd6;
  localparam logic [4:0] S_T_START    = 5'd7;
  localparam logic [4:0] S_T_NOSTART  = 5'd8;
  localparam logic [4:0] S_T_FAIL     = 5'd9;
  localparam logic [4:0] S_T_PASS     = 5'd10;
  localparam logic [4:0] S_R_START    = 5'd11;
  localparam logic [4:0] S_R_TOT      = 5'd12;
  localparam logic [4:0] S_R_CMP      = 5'd13;
  localparam logic [4:0] S_R_DONE     = 5'd14;
  localparam logic [4:0] S_R_CANCEL   = 5'd15;
  localparam logic [4:0] S_P_INIT     = 5'd16;
  localparam logic [4:0] S_P_READY    = 5'd17;
  localparam logic [4:0] S_I_START    = 5'd18;
  localparam logic [4:0] S_I_ERR      = 5'd19;
  localparam logic [4:0] S_I_DONE     = 5'd20;
  localparam logic [4:0] S_F_START    = 5'd21;
  localparam logic [4:0] S_F_ERR      = 5'd22;
  localparam logic [4:0] S_F_DONE     = 5'd23;
  localparam logic [4:0] S_F_TOT      = 5'd24;
  localparam logic [4:0] S_F_CMP      = 5'd25;
  localparam logic [4:0] S_CONN       = 5'd26;
  localparam logic [4:0] S_DISC       = 5'd27;
  localparam logic [4:0] S_DISC_BUSY  = 5'd28;

  localparam logic [4:0] PORT_OPEN  = 5'd0;
  localparam logic [4:0] PORT_CLOSE = 5'd1;

  // payload of one input beat
  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  rx_byte;
    logic [23:0] total_length;
    logic        file_ok;
  } in_beat_t;

  // payload of one result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  status_code;
    logic [7:0]  byte_value;
    logic [7:0]  second_value;
    logic [23:0] length;
    logic        last;
  } out_beat_t;

  // one classified input as it leaves the front part
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  rx;
    logic [31:0] tl;
    logic        ok;
  } item_t;

endpackage

[hw/rtl/rphls_if.sv]
// valid/ready channel interface
`timescale 1ns / 1ps
interface rphls_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rphls_front.sv]
// input clamp and two-entry queue in front of the sequencer
`timescale 1ns / 1ps
module rphls_front #(
  parameter int unsigned LENGTH_BITS = rphls_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       command_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [23:0]      total_length_i,
  input  logic             file_ok_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output rphls_pkg::item_t q_item_o
);
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  rphls_pkg::item_t mem_q [2];
  logic             rd_q, wr_q;
  logic [1:0]       cnt_q;
  rphls_pkg::item_t in_item;
  logic             push, pop;

  // clamp length to the configured length width
  always_comb begin
    in_item.cmd = rphls_pkg::cmd_e'(command_i);
    in_item.rx  = rx_byte_i;
    in_item.tl  = ({8'd0, total_length_i} > LEN_MAX) ? LEN_MAX : {8'd0, total_length_i};
    in_item.ok  = file_ok_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !q_valid_o) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("queue lost an entry");
`endif
endmodule

[hw/rtl/rphls_back.sv]
// protocol sequencer: computes results of one item, emits one beat per cycle while out_ready_i is high
`timescale 1ns / 1ps
module rphls_back #(
  parameter int unsigned CHUNK_BYTES = rphls_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned ID_BYTES    = rphls_pkg::ID_BYTES_DEF,
  parameter int unsigned LENGTH_BITS = rphls_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [23:0]      capacity_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  rphls_pkg::item_t q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       kind_o,
  output logic [4:0]       status_code_o,
  output logic [7:0]       byte_value_o,
  output logic [7:0]       second_value_o,
  output logic [23:0]      length_o,
  output logic             last_o
);
  localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned IW = $clog2(ID_BYTES + 1);
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [31:0] CHUNK32 = 32'(CHUNK_BYTES);

  typedef enum logic [4:0] {
    P_IDLE, P_W_ERASE, P_W_REPLY, P_W_FINISH, P_W_MORE,
    P_T_START, P_T_NEXT, P_T_FIRST, P_T_SECOND,
    P_R_START, P_R_DATA, P_R_STATUS,
    P_M_OK, P_M_REPLY, P_B_OK, P_B_REPLY,
    P_M_UNPLUG, P_M_PLUG, P_B_UNPLUG, P_B_PLUG,
    P_I_OK, P_I_DATA, P_I_DONE,
    P_F_START, P_F_FINISH, P_F_MORE, P_F_REPLY
  } phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [7:0]  b;
    logic [7:0]  s;
    logic [23:0] len;
  } res_t;

  phase_e      phase_q, phase_d, pend_ph_q, pend_ph_d;
  logic [7:0]  pend_cmd_q, pend_cmd_d;
  logic [31:0] rem_q, rem_d, done_q, done_d, rtot_q, rtot_d;
  logic [CW-1:0] rleft_q, rleft_d;
  logic [7:0]  fcnt_q, fcnt_d, ffp_q, ffp_d;
  logic [IW-1:0] idc_q, idc_d;
  logic        pres_q, pres_d;

  // result buffer being drained
  res_t        buf_q [rphls_pkg::MAX_RES];
  logic [2:0]  num_q, idx_q;
  res_t        r [rphls_pkg::MAX_RES];
  logic [2:0]  n;
  logic        take;
  logic [31:0] chunk, sum;
  logic [7:0]  c;

  assign q_ready_o = (num_q == 3'd0) || (out_ready_i && idx_q == num_q - 3'd1);
  assign take      = q_valid_i && q_ready_o;
  assign c         = q_item_i.rx;

  assign chunk = (rem_q < CHUNK32) ? rem_q : CHUNK32;
  assign sum   = ({1'b0, done_q} + {1'b0, chunk} > {1'b0, LEN_MAX}) ? LEN_MAX
               : done_q + chunk;

  function automatic res_t mk(logic [2:0] k, logic [4:0] cd, logic [7:0] b, logic [7:0] s,
                              logic [31:0] l);
    res_t x;
    x.kind = k; x.code = cd; x.b = b; x.s = s; x.len = l[23:0];
    return x;
  endfunction

  always_comb begin
    phase_d = phase_q; pend_ph_d = pend_ph_q; pend_cmd_d = pend_cmd_q;
    rem_d = rem_q; done_d = done_q; rtot_d = rtot_q; rleft_d = rleft_q;
    fcnt_d = fcnt_q; ffp_d = ffp_q; idc_d = idc_q; pres_d = pres_q;
    n = 3'd0;
    for (int i = 0; i < rphls_pkg::MAX_RES; i++) r[i] = '0;
    case (q_item_i.cmd)
      rphls_pkg::CMD_READ: begin
        rtot_d = '0; pend_cmd_d = rphls_pkg::B_READ; pend_ph_d = P_R_START;
        phase_d = P_M_OK;
        r[0] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_OPEN, 8'd0, 8'd0, '0);
        r[1] = mk(rphls_pkg::K_SEND, 5'd0, rphls_pkg::B_GETMODE, 8'd0, '0); n = 3'd2;
      end
      rphls_pkg::CMD_WRITE: begin
        if (!q_item_i.ok) begin
          phase_d = P_IDLE; r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_WR_ERR, 8'd0, 8'd0, '0);
          n = 3'd1;
        end else begin
          done_d = '0; rem_d = q_item_i.tl;
          pend_cmd_d = rphls_pkg::B_ERASE; pend_ph_d = P_W_ERASE; phase_d = P_M_OK;
          r[0] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_OPEN, 8'd0, 8'd0, '0);
          r[1] = mk(rphls_pkg::K_SEND, 5'd0, rphls_pkg::B_GETMODE, 8'd0, '0); n = 3'd2;
        end
      end
      rphls_pkg::CMD_TEST, rphls_pkg::CMD_IDENT: begin
        pend_cmd_d = (q_item_i.cmd == rphls_pkg::CMD_TEST) ? rphls_pkg::B_TEST
                   : rphls_pkg::B_IDENT;
        pend_ph_d = (q_item_i.cmd == rphls_pkg::CMD_TEST) ? P_T_START : P_I_OK;
        phase_d = P_M_OK;
        r[0] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_OPEN, 8'd0, 8'd0, '0);
        r[1] = mk(rphls_pkg::K_SEND, 5'd0, rphls_pkg::B_GETMODE, 8'd0, '0); n = 3'd2;
      end
      rphls_pkg::CMD_FLASH: begin
        if (!q_item_i.ok) begin
          phase_d = P_IDLE; r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_F_ERR, 8'd0, 8'd0, '0);
          n = 3'd1;
        end else begin
          done_d = '0; rem_d = q_item_i.tl;
          pend_cmd_d = rphls_pkg::B_FLASH; pend_ph_d = P_F_START; phase_d = P_B_OK;
          r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_F_TOT, 8'd0, 8'd0, q_item_i.tl);
          r[1] = mk(rphls_pkg::K_STAT, rphls_pkg::S_F_CMP, 8'd0, 8'd0, '0);
          r[2] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_OPEN, 8'd0, 8'd0, '0);
          r[3] = mk(rphls_pkg::K_SEND, 5'd0, rphls_pkg::B_GETMODE, 8'd0, '0); n = 3'd4;
        end
      end
      rphls_pkg::CMD_PLUG: begin
        if (!pres_q) begin
          pres_d = 1'b1;
          r[0] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
          if (phase_q == P_M_PLUG || phase_q == P_B_PLUG) begin
            r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_OPEN, 8'd0, 8'd0, '0);
            r[2] = mk(rphls_pkg::K_SEND, 5'd0, pend_cmd_q, 8'd0, '0);
            phase_d = pend_ph_q; n = 3'd3;
            if (phase_q == P_M_PLUG && pend_cmd_q == rphls_pkg::B_ERASE) begin
              r[3] = mk(rphls_pkg::K_STAT, rphls_pkg::S_ERASING, 8'd0, 8'd0, '0); n = 3'd4;
            end
          end else begin
            r[1] = mk(rphls_pkg::K_STAT, rphls_pkg::S_CONN, 8'd0, 8'd0, '0); n = 3'd2;
          end
        end
      end
      rphls_pkg::CMD_REMOVE: begin
        if (pres_q) begin
          pres_d = 1'b0;
          if (phase_q == P_M_UNPLUG) phase_d = P_M_PLUG;
          else if (phase_q == P_B_UNPLUG) phase_d = P_B_PLUG;
          else begin
            r[0] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
            r[1] = mk(rphls_pkg::K_STAT, (phase_q != P_IDLE) ? rphls_pkg::S_DISC_BUSY
                      : rphls_pkg::S_DISC, 8'd0, 8'd0, '0);
            phase_d = P_IDLE; n = 3'd2;
          end
        end
      end
      default: begin
        // received byte
        case (phase_q)
          P_W_ERASE: begin
            if (c == 8'd0) begin
              phase_d = P_W_REPLY;
              r[0] = mk(rphls_pkg::K_SEND, 5'd0, rphls_pkg::B_WRITE, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_STAT, rphls_pkg::S_ER_DONE, 8'd0, 8'd0, '0);
              r[2] = mk(rphls_pkg::K_STAT, rphls_pkg::S_WR_TOT, 8'd0, 8'd0, rem_q);
              r[3] = mk(rphls_pkg::K_STAT, rphls_pkg::S_WR_CMP, 8'd0, 8'd0, done_q); n = 3'd4;
            end else if (c == 8'd1) begin
              phase_d = P_IDLE;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_ER_FAIL, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0); n = 3'd2;
            end
          end
          P_W_REPLY, P_F_REPLY: begin
            if (c == 8'd0) begin
              n = 3'd1;
              if (rem_q != '0) begin
                r[0] = mk(rphls_pkg::K_SEND, 5'd0, 8'd0, 8'd0, '0);
                phase_d = (phase_q == P_W_REPLY) ? P_W_MORE : P_F_MORE;
              end else begin
                r[0] = mk(rphls_pkg::K_SEND, 5'd0, 8'd1, 8'd0, '0);
                phase_d = (phase_q == P_W_REPLY) ? P_W_FINISH : P_F_FINISH;
              end
            end else if (c == 8'd1 || phase_q == P_F_REPLY) begin
              phase_d = P_IDLE;
              r[0] = mk(rphls_pkg::K_STAT, (phase_q == P_W_REPLY) ? rphls_pkg::S_WR_ERR
                        : rphls_pkg::S_F_ERR, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0); n = 3'd2;
            end
          end
          P_W_MORE, P_F_MORE: begin
            if (c == 8'd0) begin
              r[0] = mk(rphls_pkg::K_CHUNK, 5'd0, rphls_pkg::PAD_BYTE, 8'd0, chunk);
              r[1] = mk(rphls_pkg::K_STAT, (phase_q == P_W_MORE) ? rphls_pkg::S_WR_CMP
                        : rphls_pkg::S_F_CMP, 8'd0, 8'd0, sum);
              rem_d = rem_q - chunk; done_d = sum; n = 3'd2;
              phase_d = (phase_q == P_W_MORE) ? P_W_REPLY : P_F_REPLY;
            end else begin
              phase_d = P_IDLE;
              r[0] = mk(rphls_pkg::K_STAT, (phase_q == P_W_MORE) ? rphls_pkg::S_WR_ERR
                        : rphls_pkg::S_F_ERR, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0); n = 3'd2;
            end
          end
          P_W_FINISH, P_F_FINISH, P_T_START: begin
            phase_d = P_IDLE; n = 3'd2;
            r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
            if (phase_q == P_W_FINISH)
              r[0] = mk(rphls_pkg::K_STAT, (c == 8'd0) ? rphls_pkg::S_WR_DONE
                        : rphls_pkg::S_WR_ERR, 8'd0, 8'd0, '0);
            else if (phase_q == P_F_FINISH)
              r[0] = mk(rphls_pkg::K_STAT, (c == 8'd0) ? rphls_pkg::S_F_DONE
                        : rphls_pkg::S_F_ERR, 8'd0, 8'd0, '0);
            else if (c == 8'd0) begin
              phase_d = P_T_NEXT; fcnt_d = '0; n = 3'd1;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_T_START, 8'd0, 8'd0, '0);
              r[1] = '0;
            end else
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_T_NOSTART, 8'd0, 8'd0, '0);
          end
          P_T_NEXT: begin
            if (c == 8'd1) begin
              phase_d = P_IDLE; n = 3'd2;
              r[0] = mk(rphls_pkg::K_STAT, (fcnt_q != 8'd0) ? rphls_pkg::S_T_FAIL
                        : rphls_pkg::S_T_PASS, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
            end else if (c == 8'd0) begin
              if (fcnt_q != 8'hFF) fcnt_d = fcnt_q + 8'd1;
              phase_d = P_T_FIRST;
            end
          end
          P_T_FIRST: begin
            ffp_d = c; phase_d = P_T_SECOND;
          end
          P_T_SECOND: begin
            r[0] = mk(rphls_pkg::K_FAIL, 5'd0, ffp_q, c, '0); n = 3'd1; phase_d = P_T_NEXT;
          end
          P_R_START: begin
            phase_d = P_R_DATA; rleft_d = CW'(CHUNK_BYTES); n = 3'd3;
            r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_R_START, 8'd0, 8'd0, '0);
            r[1] = mk(rphls_pkg::K_STAT, rphls_pkg::S_R_TOT, 8'd0, 8'd0,
                      {8'd0, capacity_i} & LEN_MAX);
            r[2] = mk(rphls_pkg::K_STAT, rphls_pkg::S_R_CMP, 8'd0, 8'd0, '0);
          end
          P_R_DATA: begin
            r[0] = mk(rphls_pkg::K_RDATA, 5'd0, c, 8'd0, '0); n = 3'd1;
            rtot_d = (rtot_q == LEN_MAX) ? rtot_q : rtot_q + 32'd1;
            rleft_d = (rleft_q != '0) ? rleft_q - CW'(1) : rleft_q;
            if (rleft_d == '0) begin
              r[1] = mk(rphls_pkg::K_STAT, rphls_pkg::S_R_CMP, 8'd0, 8'd0, rtot_d);
              r[2] = mk(rphls_pkg::K_SEND, 5'd0, 8'd0, 8'd0, '0);
              phase_d = P_R_STATUS; n = 3'd3;
            end
          end
          P_R_STATUS: begin
            if (c == 8'd3 || c == 8'd4) begin
              phase_d = P_IDLE; n = 3'd2;
              r[0] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_STAT, (c == 8'd3) ? rphls_pkg::S_R_DONE
                        : rphls_pkg::S_R_CANCEL, 8'd0, 8'd0, '0);
            end else if (c == 8'd2) begin
              phase_d = P_R_DATA; rleft_d = CW'(CHUNK_BYTES);
            end
          end
          P_M_OK: phase_d = (c == 8'd0) ? P_M_REPLY : P_IDLE;
          P_B_OK: phase_d = (c == 8'd0) ? P_B_REPLY : P_IDLE;
          P_M_REPLY, P_B_REPLY: begin
            // switch byte needed when mode differs from the one wanted
            if ((phase_q == P_M_REPLY && c == 8'd0) || (phase_q == P_B_REPLY && c == 8'd1)) begin
              n = 3'd3;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_P_INIT, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_SEND, 5'd0, (phase_q == P_M_REPLY) ? rphls_pkg::B_TOPROG
                        : rphls_pkg::B_TOBOOT, 8'd0, '0);
              r[2] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
              phase_d = (phase_q == P_M_REPLY) ? P_M_UNPLUG : P_B_UNPLUG;
            end else if (c == 8'd0 || c == 8'd1) begin
              n = 3'd2; phase_d = pend_ph_q;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_P_READY, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_SEND, 5'd0, pend_cmd_q, 8'd0, '0);
              if (phase_q == P_M_REPLY && pend_cmd_q == rphls_pkg::B_ERASE) begin
                r[2] = mk(rphls_pkg::K_STAT, rphls_pkg::S_ERASING, 8'd0, 8'd0, '0); n = 3'd3;
              end
            end
          end
          P_I_OK: begin
            n = 3'd1;
            if (c == 8'd0) begin
              phase_d = P_I_DATA; idc_d = '0;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_I_START, 8'd0, 8'd0, '0);
            end else begin
              phase_d = P_IDLE;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_I_ERR, 8'd0, 8'd0, '0);
            end
          end
          P_I_DATA: begin
            r[0] = mk(rphls_pkg::K_ID, 5'd0, c, 8'(idc_q), '0); n = 3'd1;
            idc_d = idc_q + IW'(1);
            if (idc_d >= IW'(ID_BYTES)) phase_d = P_I_DONE;
          end
          P_I_DONE: begin
            n = 3'd1; phase_d = P_IDLE;
            r[0] = mk(rphls_pkg::K_STAT, (c == 8'd0) ? rphls_pkg::S_I_DONE
                      : rphls_pkg::S_I_ERR, 8'd0, 8'd0, '0);
          end
          P_F_START: begin
            if (c == 8'd0) begin
              n = 3'd2; phase_d = P_F_MORE;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_F_START, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_SEND, 5'd0, 8'd0, 8'd0, '0);
            end else begin
              n = 3'd2; phase_d = P_IDLE;
              r[0] = mk(rphls_pkg::K_STAT, rphls_pkg::S_F_ERR, 8'd0, 8'd0, '0);
              r[1] = mk(rphls_pkg::K_PORT, rphls_pkg::PORT_CLOSE, 8'd0, 8'd0, '0);
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; pend_ph_q <= P_IDLE; pend_cmd_q <= '0;
      rem_q <= '0; done_q <= '0; rtot_q <= '0; rleft_q <= '0;
      fcnt_q <= '0; ffp_q <= '0; idc_q <= '0; pres_q <= 1'b0;
      num_q <= '0; idx_q <= '0;
    end else begin
      if (take) begin
        phase_q <= phase_d; pend_ph_q <= pend_ph_d; pend_cmd_q <= pend_cmd_d;
        rem_q <= rem_d; done_q <= done_d; rtot_q <= rtot_d; rleft_q <= rleft_d;
        fcnt_q <= fcnt_d; ffp_q <= ffp_d; idc_q <= idc_d; pres_q <= pres_d;
        num_q <= n; idx_q <= '0;
      end else if (out_valid_o && out_ready_i) begin
        if (idx_q == num_q - 3'd1) num_q <= '0;
        else idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) for (int i = 0; i < rphls_pkg::MAX_RES; i++) buf_q[i] <= r[i];
  end

  assign out_valid_o    = (num_q != 3'd0);
  assign kind_o         = buf_q[idx_q].kind;
  assign status_code_o  = buf_q[idx_q].code;
  assign byte_value_o   = buf_q[idx_q].b;
  assign second_value_o = buf_q[idx_q].s;
  assign length_o       = buf_q[idx_q].len;
  assign last_o         = (idx_q == num_q - 3'd1);

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < num_q) else $error("beat index past result count");
  a_num_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q <= 3'(rphls_pkg::MAX_RES)) else $error("too many results");
  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (num_q == 3'd0) || (out_ready_i && last_o)) else $error("overwrote pending results");
`endif
endmodule

[hw/rtl/rom_programmer_host_link_sequencer_core.sv]
// top level of the programmer host link sequencer
//
//  channel   dir  payload
//  in_if     in   command, rx_byte, total_length, file_ok
//  out_if    out  kind, status_code, byte_value, second_value, length, last
//  apb       in   device_capacity at address 0
//
// an item is taken in the same cycle the previous item's last beat leaves,
// so an item producing k results (up to four) holds the back part until
// its beats have left, drained one beat per cycle while out_if is ready
// a two-entry input queue lets the input side run ahead while results stall
// reset is asynchronous active low and clears all sequencing state
`timescale 1ns / 1ps
module rom_programmer_host_link_sequencer_core #(
  parameter int unsigned CHUNK_BYTES = rphls_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned ID_BYTES    = rphls_pkg::ID_BYTES_DEF,
  parameter int unsigned LENGTH_BITS = rphls_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rphls_if.sink       in_if,
  rphls_if.source     out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [23:0]      cap_q;
  logic             q_valid, q_ready;
  rphls_pkg::item_t q_item;

  // device capacity register, the only config register
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {8'd0, cap_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      cap_q <= pwdata[23:0];
    end
  end

  // front: queue of incoming beats
  rphls_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .command_i(in_if.data.command), .rx_byte_i(in_if.data.rx_byte),
    .total_length_i(in_if.data.total_length), .file_ok_i(in_if.data.file_ok),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  // back: sequencer and result drain
  rphls_back #(.CHUNK_BYTES(CHUNK_BYTES), .ID_BYTES(ID_BYTES),
               .LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i, .rst_ni, .capacity_i(cap_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .kind_o(out_if.data.kind), .status_code_o(out_if.data.status_code),
    .byte_value_o(out_if.data.byte_value), .second_value_o(out_if.data.second_value),
    .length_o(out_if.data.length), .last_o(out_if.data.last)
  );

`ifndef NO_ASSERTIONS
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_cap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(cap_q)) else $error("capacity changed");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paddr == 2'd0 |-> prdata[23:0] == cap_q) else $error("readback mismatch");
`endif
endmodule

[test/tb_rom_programmer_host_link_sequencer_core.sv]
// self-checking testbench for the programmer host link sequencer core
`timescale 1ns / 1ps
module tb_rom_programmer_host_link_sequencer_core;
  import rphls_pkg::*;

  // result beat as it leaves the block, fields in port order
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [7:0]  bval;
    logic [7:0]  sval;
    logic [23:0] len;
    logic        last;
  } res_t;

  // sequencing phases of the host protocol
  typedef enum logic [4:0] {
    PH_IDLE, PH_W_ERASE, PH_W_REPLY, PH_W_FINISH, PH_W_MORE,
    PH_T_START, PH_T_NEXT, PH_T_FIRST, PH_T_SECOND,
    PH_R_START, PH_R_DATA, PH_R_STATUS,
    PH_M_OK, PH_M_REPLY, PH_B_OK, PH_B_REPLY,
    PH_M_UNPLUG, PH_M_PLUG, PH_B_UNPLUG, PH_B_PLUG,
    PH_I_OK, PH_I_DATA, PH_I_DONE,
    PH_F_START, PH_F_FINISH, PH_F_MORE, PH_F_REPLY
  } phase_e;

  localparam int unsigned CHUNK   = 1024;
  localparam int unsigned IDN     = 8;
  localparam logic [23:0] LEN_MAX = 24'hFFFFFF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned TARGET_ITEMS = 460;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  rphls_if #(.T(in_beat_t))  in_ch ();
  rphls_if #(.T(out_beat_t)) out_ch ();

  rom_programmer_host_link_sequencer_core u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // host sequencer model: own copy of state and of the capacity register
  // ---------------------------------------------------------------------------
  phase_e      ph, pend_ph;
  logic [7:0]  pend_cmd;
  logic [23:0] bytes_left, bytes_sent, rd_total, capacity;
  logic [10:0] rd_left;
  logic [7:0]  fails, first_pin;
  logic [3:0]  id_idx;
  logic        present;

  res_t beats_of_item[$];  // results of the item being predicted
  res_t pending_beats[$];  // results still to come out of the block

  int errors = 0;
  int n_items = 0;
  int n_accepted = 0;
  int n_results = 0;

  function automatic logic [23:0] add_sat(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? LEN_MAX : s[23:0];
  endfunction

  function automatic void emit(logic [2:0] k, logic [4:0] c, logic [7:0] b,
                               logic [7:0] s, logic [23:0] l);
    res_t r;
    r.kind = k; r.code = c; r.bval = b; r.sval = s; r.len = l; r.last = 1'b0;
    if (beats_of_item.size() < MAX_RES) beats_of_item.push_back(r);
  endfunction

  function automatic void tx(logic [7:0] b);
    emit(K_SEND, 5'd0, b, 8'd0, 24'd0);
  endfunction

  function automatic void stat(logic [4:0] c, logic [23:0] l);
    emit(K_STAT, c, 8'd0, 8'd0, l);
  endfunction

  function automatic void port_ctl(logic [4:0] c);
    emit(K_PORT, c, 8'd0, 8'd0, 24'd0);
  endfunction

  // every operation opens the port and asks the board for its mode
  function automatic void open_op(logic [7:0] c, phase_e nxt, bit boot);
    pend_cmd = c;
    pend_ph  = nxt;
    ph = boot ? PH_B_OK : PH_M_OK;
    port_ctl(PORT_OPEN);
    tx(B_GETMODE);
  endfunction

  function automatic void run_pending();
    ph = pend_ph;
    tx(pend_cmd);
    if (pend_cmd == B_ERASE) stat(S_ERASING, 24'd0);
  endfunction

  function automatic void abort_op(logic [4:0] c);
    ph = PH_IDLE;
    stat(c, 24'd0);
    port_ctl(PORT_CLOSE);
  endfunction

  function automatic void chunk_out(logic [4:0] c, phase_e nxt);
    logic [23:0] n;
    n = (bytes_left < CHUNK) ? bytes_left : 24'(CHUNK);
    emit(K_CHUNK, 5'd0, PAD_BYTE, 8'd0, n);
    ph = nxt;
    bytes_left = bytes_left - n;
    bytes_sent = add_sat(bytes_sent, n);
    stat(c, bytes_sent);
  endfunction

  // one reply byte from the board
  function automatic void take_byte(logic [7:0] c);
    case (ph)
      PH_W_ERASE: begin
        if (c == 8'd0) begin
          tx(B_WRITE);
          ph = PH_W_REPLY;
          stat(S_ER_DONE, 24'd0);
          stat(S_WR_TOT, bytes_left);
          stat(S_WR_CMP, bytes_sent);
        end else if (c == 8'd1) begin
          abort_op(S_ER_FAIL);
        end
      end
      PH_W_REPLY: begin
        if (c == 8'd0) begin
          if (bytes_left > 0) begin tx(8'd0); ph = PH_W_MORE; end
          else begin tx(8'd1); ph = PH_W_FINISH; end
        end else if (c == 8'd1) begin
          abort_op(S_WR_ERR);
        end
      end
      PH_W_MORE: if (c == 8'd0) chunk_out(S_WR_CMP, PH_W_REPLY); else abort_op(S_WR_ERR);
      PH_W_FINISH: abort_op(c == 8'd0 ? S_WR_DONE : S_WR_ERR);
      PH_T_START: begin
        if (c == 8'd0) begin ph = PH_T_NEXT; stat(S_T_START, 24'd0); fails = 8'd0; end
        else abort_op(S_T_NOSTART);
      end
      PH_T_NEXT: begin
        if (c == 8'd1) abort_op(fails > 0 ? S_T_FAIL : S_T_PASS);
        else if (c == 8'd0) begin
          if (fails != 8'hFF) fails = fails + 8'd1;
          ph = PH_T_FIRST;
        end
      end
      PH_T_FIRST: begin first_pin = c; ph = PH_T_SECOND; end
      PH_T_SECOND: begin emit(K_FAIL, 5'd0, first_pin, c, 24'd0); ph = PH_T_NEXT; end
      PH_R_START: begin
        stat(S_R_START, 24'd0);
        ph = PH_R_DATA;
        stat(S_R_TOT, capacity);
        stat(S_R_CMP, 24'd0);
        rd_left = 11'(CHUNK);
      end
      PH_R_DATA: begin
        emit(K_RDATA, 5'd0, c, 8'd0, 24'd0);
        rd_total = add_sat(rd_total, 24'd1);
        if (rd_left > 0) rd_left = rd_left - 11'd1;
        if (rd_left == 0) begin
          stat(S_R_CMP, rd_total);
          tx(8'd0);
          ph = PH_R_STATUS;
        end
      end
      PH_R_STATUS: begin
        if (c == 8'd3 || c == 8'd4) begin
          ph = PH_IDLE;
          port_ctl(PORT_CLOSE);
          stat(c == 8'd3 ? S_R_DONE : S_R_CANCEL, 24'd0);
        end else if (c == 8'd2) begin
          ph = PH_R_DATA;
          rd_left = 11'(CHUNK);
        end
      end
      // a refused mode query drops the operation without a word
      PH_M_OK: ph = (c == 8'd0) ? PH_M_REPLY : PH_IDLE;
      PH_B_OK: ph = (c == 8'd0) ? PH_B_REPLY : PH_IDLE;
      PH_M_REPLY: begin
        if (c == 8'd0) begin
          stat(S_P_INIT, 24'd0); tx(B_TOPROG); port_ctl(PORT_CLOSE); ph = PH_M_UNPLUG;
        end else if (c == 8'd1) begin
          stat(S_P_READY, 24'd0); run_pending();
        end
      end
      PH_B_REPLY: begin
        if (c == 8'd1) begin
          stat(S_P_INIT, 24'd0); tx(B_TOBOOT); port_ctl(PORT_CLOSE); ph = PH_B_UNPLUG;
        end else if (c == 8'd0) begin
          stat(S_P_READY, 24'd0); ph = pend_ph; tx(pend_cmd);
        end
      end
      PH_I_OK: begin
        if (c == 8'd0) begin stat(S_I_START, 24'd0); ph = PH_I_DATA; id_idx = 4'd0; end
        else begin stat(S_I_ERR, 24'd0); ph = PH_IDLE; end
      end
      PH_I_DATA: begin
        emit(K_ID, 5'd0, c, 8'(id_idx), 24'd0);
        id_idx = id_idx + 4'd1;
        if (id_idx >= IDN) ph = PH_I_DONE;
      end
      PH_I_DONE: begin
        stat(c == 8'd0 ? S_I_DONE : S_I_ERR, 24'd0);
        ph = PH_IDLE;
      end
      PH_F_START: begin
        if (c == 8'd0) begin stat(S_F_START, 24'd0); tx(8'd0); ph = PH_F_MORE; end
        else abort_op(S_F_ERR);
      end
      PH_F_FINISH: abort_op(c == 8'd0 ? S_F_DONE : S_F_ERR);
      PH_F_MORE: if (c == 8'd0) chunk_out(S_F_CMP, PH_F_REPLY); else abort_op(S_F_ERR);
      PH_F_REPLY: begin
        if (c == 8'd0) begin
          if (bytes_left > 0) begin tx(8'd0); ph = PH_F_MORE; end
          else begin tx(8'd1); ph = PH_F_FINISH; end
        end else abort_op(S_F_ERR);
      end
      default: ;
    endcase
  endfunction

  // work out the results of one accepted input beat
  function automatic void predict_item(in_beat_t it);
    logic [23:0] tl;
    tl = it.total_length;
    beats_of_item.delete();
    case (cmd_e'(it.command))
      CMD_READ: begin rd_total = 24'd0; open_op(B_READ, PH_R_START, 1'b0); end
      CMD_WRITE: begin
        if (!it.file_ok) begin ph = PH_IDLE; stat(S_WR_ERR, 24'd0); end
        else begin
          bytes_sent = 24'd0; bytes_left = tl;
          open_op(B_ERASE, PH_W_ERASE, 1'b0);
        end
      end
      CMD_TEST:  open_op(B_TEST, PH_T_START, 1'b0);
      CMD_IDENT: open_op(B_IDENT, PH_I_OK, 1'b0);
      CMD_FLASH: begin
        if (!it.file_ok) begin ph = PH_IDLE; stat(S_F_ERR, 24'd0); end
        else begin
          bytes_sent = 24'd0; bytes_left = tl;
          stat(S_F_TOT, bytes_left);
          stat(S_F_CMP, 24'd0);
          open_op(B_FLASH, PH_F_START, 1'b1);
        end
      end
      CMD_BYTE: take_byte(it.rx_byte);
      CMD_PLUG: begin
        if (!present) begin
          present = 1'b1;
          port_ctl(PORT_CLOSE);
          if (ph == PH_M_PLUG) begin port_ctl(PORT_OPEN); run_pending(); end
          else if (ph == PH_B_PLUG) begin
            port_ctl(PORT_OPEN); ph = pend_ph; tx(pend_cmd);
          end else stat(S_CONN, 24'd0);
        end
      end
      default: begin
        if (present) begin
          present = 1'b0;
          if (ph == PH_M_UNPLUG) ph = PH_M_PLUG;
          else if (ph == PH_B_UNPLUG) ph = PH_B_PLUG;
          else begin
            port_ctl(PORT_CLOSE);
            if (ph != PH_IDLE) begin ph = PH_IDLE; stat(S_DISC_BUSY, 24'd0); end
            else stat(S_DISC, 24'd0);
          end
        end
      end
    endcase
    if (beats_of_item.size() > 0) beats_of_item[beats_of_item.size() - 1].last = 1'b1;
    foreach (beats_of_item[i]) pending_beats.push_back(beats_of_item[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: feeds beats from the stimulus queue with random gaps
  // ---------------------------------------------------------------------------
  in_beat_t stim_q[$];
  bit    no_gaps = 1'b0;
  int    gap_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.data);
        n_accepted++;
      end
      // load a new beat only once the current one is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_ch.valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= stim_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random stalls plus one long hold-off to back up the block
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;
  res_t want;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %p", $realtime, out_ch.data);
        end else begin
          want = pending_beats.pop_front();
          if (out_ch.data.kind !== want.kind) begin
            errors++;
            $display("%0t: kind exp %0d got %0d", $realtime, want.kind, out_ch.data.kind);
          end
          if (out_ch.data.status_code !== want.code) begin
            errors++;
            $display("%0t: status_code exp %0d got %0d", $realtime, want.code,
                     out_ch.data.status_code);
          end
          if (out_ch.data.byte_value !== want.bval) begin
            errors++;
            $display("%0t: byte_value exp %0h got %0h", $realtime, want.bval,
                     out_ch.data.byte_value);
          end
          if (out_ch.data.second_value !== want.sval) begin
            errors++;
            $display("%0t: second_value exp %0h got %0h", $realtime, want.sval,
                     out_ch.data.second_value);
          end
          if (out_ch.data.length !== want.len) begin
            errors++;
            $display("%0t: length exp %0d got %0d", $realtime, want.len,
                     out_ch.data.length);
          end
          if (out_ch.data.last !== want.last) begin
            errors++;
            $display("%0t: last exp %0b got %0b", $realtime, want.last, out_ch.data.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && n_results >= 150) begin
        // long hold so the input queue fills and the block pushes back
        long_hold_done = 1'b1;
        stall_left = 80;
        out_ch.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  bit gen_present = 1'b0;
  int noise_pct = 4;

  task automatic push(cmd_e c, logic [7:0] rx, logic [23:0] tl, logic ok);
    in_beat_t it;
    it.command = c; it.rx_byte = rx; it.total_length = tl; it.file_ok = ok;
    stim_q.push_back(it);
    n_items++;
    if (c == CMD_PLUG) gen_present = 1'b1;
    if (c == CMD_REMOVE) gen_present = 1'b0;
  endtask

  // board reply, now and then replaced by a random byte
  task automatic reply(logic [7:0] b);
    logic [7:0] v;
    v = ($urandom_range(0, 99) < noise_pct) ? 8'($urandom) : b;
    push(CMD_BYTE, v, 24'($urandom), 1'($urandom));
  endtask

  // mode query; sometimes the board is in the wrong mode and gets replugged
  task automatic mode_check(bit boot);
    bit sw;
    sw = ($urandom_range(0, 3) == 0);
    if (!gen_present) push(CMD_PLUG, 8'd0, 24'd0, 1'b0);
    reply(8'd0);
    if (boot) reply(sw ? 8'd1 : 8'd0);
    else reply(sw ? 8'd0 : 8'd1);
    if (sw) begin
      push(CMD_REMOVE, 8'($urandom), 24'($urandom), 1'($urandom));
      push(CMD_PLUG, 8'($urandom), 24'($urandom), 1'($urandom));
    end
  endtask

  function automatic logic [23:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'(CHUNK);
      2: return 24'($urandom_range(1, 64));
      default: return 24'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic seq_write(logic [23:0] tl, int max_chunks);
    int left, k;
    push(CMD_WRITE, 8'($urandom), tl, 1'b1);
    mode_check(1'b0);
    reply(8'd0);
    left = tl; k = 0;
    while (left > 0 && k < max_chunks) begin
      reply(8'd0); reply(8'd0);
      left -= (left < CHUNK) ? left : CHUNK;
      k++;
    end
    if (left == 0) begin
      reply(8'd0);
      reply($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd0);
    end
  endtask

  task automatic seq_flash(logic [23:0] tl, int max_chunks);
    int left, k;
    push(CMD_FLASH, 8'($urandom), tl, 1'b1);
    mode_check(1'b1);
    reply(8'd0);
    left = tl; k = 0;
    do begin
      reply(8'd0);
      left -= (left < CHUNK) ? left : CHUNK;
      reply(8'd0);
      k++;
    end while (left > 0 && k < max_chunks);
    if (left == 0) reply($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd0);
  endtask

  task automatic seq_test();
    int n;
    push(CMD_TEST, 8'($urandom), 24'($urandom), 1'($urandom));
    mode_check(1'b0);
    reply(8'd0);
    n = $urandom_range(0, 4);
    repeat (n) begin
      reply(8'd0); reply(8'($urandom)); reply(8'($urandom));
    end
    reply(8'd1);
  endtask

  task automatic seq_ident();
    push(CMD_IDENT, 8'($urandom), 24'($urandom), 1'($urandom));
    mode_check(1'b0);
    reply(8'd0);
    repeat (IDN) reply(8'($urandom));
    reply($urandom_range(0, 2) == 0 ? 8'd1 : 8'd0);
  endtask

  task automatic seq_read(int n);
    push(CMD_READ, 8'($urandom), 24'($urandom), 1'($urandom));
    mode_check(1'b0);
    reply(8'd0);
    repeat (n) reply(8'($urandom));
  endtask

  task automatic noise(int n);
    repeat (n) push(cmd_e'($urandom_range(0, 7)), 8'($urandom), 24'($urandom), 1'($urandom));
  endtask

  // register access over the configuration port
  task automatic cfg_write(logic [23:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {8'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    capacity = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // read it back
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[23:0] !== v) begin
      errors++;
      $display("%0t: device_capacity exp %0h got %0h", $realtime, v, prdata[23:0]);
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  // let every queued beat go in and every expected result come out
  task automatic drain();
    while (stim_q.size() > 0 || in_ch.valid || pending_beats.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  logic [23:0] cap_set [4];

  initial begin
    ph = PH_IDLE; pend_ph = PH_IDLE; pend_cmd = 8'd0;
    bytes_left = 24'd0; bytes_sent = 24'd0; rd_total = 24'd0; capacity = 24'd0;
    rd_left = 11'd0; fails = 8'd0; first_pin = 8'd0; id_idx = 4'd0; present = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 2'd0; pwdata = 32'd0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cap_set[0] = LEN_MAX;
    cap_set[1] = 24'd0;
    cap_set[2] = 24'($urandom);
    cap_set[3] = 24'd524288;

    // directed: board events, refused starts, refused mode, edge lengths
    cfg_write(cap_set[0]);
    noise_pct = 0;
    push(CMD_BYTE, 8'hFF, LEN_MAX, 1'b1);       // byte while idle
    push(CMD_REMOVE, 8'd0, 24'd0, 1'b0);        // remove while absent
    push(CMD_PLUG, 8'd0, 24'd0, 1'b0);
    push(CMD_PLUG, 8'd0, 24'd0, 1'b0);          // plug while present
    push(CMD_REMOVE, 8'd0, 24'd0, 1'b0);        // disconnect while idle
    push(CMD_PLUG, 8'd0, 24'd0, 1'b0);
    push(CMD_WRITE, 8'd0, 24'd100, 1'b0);       // image did not open
    push(CMD_FLASH, 8'd0, LEN_MAX, 1'b0);
    push(CMD_TEST, 8'd0, 24'd0, 1'b0);
    push(CMD_BYTE, 8'd1, 24'd0, 1'b0);          // mode query refused
    push(CMD_IDENT, 8'd0, 24'd0, 1'b0);
    push(CMD_BYTE, 8'd0, 24'd0, 1'b0);
    push(CMD_BYTE, 8'd5, 24'd0, 1'b0);          // odd mode reply is ignored
    push(CMD_BYTE, 8'd1, 24'd0, 1'b0);
    push(CMD_BYTE, 8'd7, 24'd0, 1'b0);          // identify refused
    seq_write(24'd0, 4);                        // empty image
    push(CMD_FLASH, 8'd0, LEN_MAX, 1'b1);       // huge image
    push(CMD_BYTE, 8'd0, 24'd0, 1'b0);
    push(CMD_BYTE, 8'd0, 24'd0, 1'b0);
    push(CMD_REMOVE, 8'd0, 24'd0, 1'b0);        // unplug mid-operation
    drain();

    // random part over the remaining capacity settings
    for (int p = 1; p < 4; p++) begin
      cfg_write(cap_set[p]);
      noise_pct = 4;
      if (p == 3) no_gaps = 1'b1;
      while (n_items < TARGET_ITEMS * p / 3) begin
        case ($urandom_range(0, 9))
          0, 1: seq_write(pick_len(), 4);
          2, 3: seq_flash(pick_len(), 4);
          4:    seq_test();
          5:    seq_ident();
          6:    seq_read($urandom_range(0, 20));
          7:    begin
                  seq_read($urandom_range(0, 8));
                  seq_flash(LEN_MAX, 2);
                end
          8:    noise($urandom_range(1, 4));
          default: seq_write(24'($urandom_range(1, 2048)), $urandom_range(0, 1));
        endcase
        while (stim_q.size() > 20) @(posedge clk);
      end
      drain();
    end

    $display("summary: %0d input beats, %0d result beats checked, 4 capacity settings",
             n_accepted, n_results);
    $display("covered write, flash, test, identify, read, mode switching and board events");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
